FILE: rtl/btpwm_pkg.sv
// Shared constants, types and state encoding of the timer with PWM ratio unit.
package btpwm_pkg;

  localparam int unsigned NumRegs = 21;

  // Item commands.
  localparam logic [1:0] CmdRead  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdTick  = 2'd2;

  // Access sizes.
  localparam logic [1:0] Size1 = 2'd0;
  localparam logic [1:0] Size2 = 2'd1;

  // Register word indexes.
  localparam logic [4:0] IdxCr1   = 5'd0;
  localparam logic [4:0] IdxDier  = 5'd3;
  localparam logic [4:0] IdxSr    = 5'd4;
  localparam logic [4:0] IdxCcmr1 = 5'd6;
  localparam logic [4:0] IdxCcmr2 = 5'd7;
  localparam logic [4:0] IdxCcer  = 5'd8;
  localparam logic [4:0] IdxPsc   = 5'd10;
  localparam logic [4:0] IdxArr   = 5'd11;
  localparam logic [4:0] IdxCcr1  = 5'd13;
  localparam logic [4:0] IdxCcr2  = 5'd14;

  // Field masks.
  localparam logic [31:0] CntModeMask = 32'h0000_0070;
  localparam logic [31:0] Oc1ModeMask = 32'h0000_0060;
  localparam logic [31:0] Cc1SelMask  = 32'h0000_0003;
  localparam logic [31:0] Oc2ModeMask = 32'h0000_6000;
  localparam logic [31:0] Cc2SelMask  = 32'h0000_0300;
  localparam logic [31:0] Cc1EnMask   = 32'h0000_0001;
  localparam logic [31:0] Cc2EnMask   = 32'h0000_0010;

  localparam logic [7:0] RatioMax = 8'd255;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StPrep,
    StCmp,
    StDiv,
    StFinish
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic prep;
    logic cmp;
    logic div;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic sat;
    logic div_last;
  } dp_status_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        pwm_en;
    logic [7:0]  ratio;
    logic        upd;
    logic        err;
  } result_t;

endpackage

FILE: rtl/btpwm_ctrl.sv
// Controller state machine that sequences execution and the ratio division.
module btpwm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_free_i,
  input  btpwm_pkg::dp_status_t status_i,
  output logic                  in_stall_o,
  output logic                  load_o,
  output btpwm_pkg::dp_cmd_t    cmd_o
);

  btpwm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btpwm_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      btpwm_pkg::StIdle: begin
        if (in_valid_i) state_d = btpwm_pkg::StExec;
      end
      btpwm_pkg::StExec: begin
        state_d = status_i.need_div ? btpwm_pkg::StPrep : btpwm_pkg::StFinish;
      end
      btpwm_pkg::StPrep: state_d = btpwm_pkg::StCmp;
      btpwm_pkg::StCmp: begin
        state_d = status_i.sat ? btpwm_pkg::StFinish : btpwm_pkg::StDiv;
      end
      btpwm_pkg::StDiv: begin
        if (status_i.div_last) state_d = btpwm_pkg::StFinish;
      end
      btpwm_pkg::StFinish: begin
        if (out_free_i) state_d = btpwm_pkg::StIdle;
      end
      default: state_d = btpwm_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != btpwm_pkg::StIdle);
    cmd_o.capture = (state_q == btpwm_pkg::StIdle) && in_valid_i;
    cmd_o.exec    = (state_q == btpwm_pkg::StExec);
    cmd_o.prep    = (state_q == btpwm_pkg::StPrep);
    cmd_o.cmp     = (state_q == btpwm_pkg::StCmp);
    cmd_o.div     = (state_q == btpwm_pkg::StDiv);
    load_o        = (state_q == btpwm_pkg::StFinish) && out_free_i;
  end

endmodule

FILE: rtl/btpwm_dp.sv
// Datapath: register file, tick counter, byte lanes and the ratio divider.
module btpwm_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  btpwm_pkg::dp_cmd_t    cmd_i,
  input  logic [1:0]            command_i,
  input  logic [4:0]            reg_index_i,
  input  logic [1:0]            byte_offset_i,
  input  logic [1:0]            access_size_i,
  input  logic [31:0]           write_data_i,
  output btpwm_pkg::dp_status_t status_o,
  output btpwm_pkg::result_t    result_o
);

  // Captured request.
  logic [1:0]  cmd_q;
  logic [4:0]  idx_q;
  logic [1:0]  off_q;
  logic [1:0]  size_q;
  logic [31:0] wd_q;

  // Architectural state.
  logic [31:0] cr1_q, cr1_d, dier_q, dier_d, sr_q, sr_d, ccmr1_q, ccmr1_d;
  logic [31:0] ccmr2_q, ccmr2_d, ccer_q, ccer_d, psc_q, psc_d, arr_q, arr_d;
  logic [31:0] ccr1_q, ccr1_d, ccr2_q, ccr2_d, tick_q, tick_d;
  logic        irq_q, irq_d, en_q, en_d;
  logic [7:0]  ratio_q, ratio_d;

  // Result fields of the current request.
  logic [31:0] rd_q, rd_d;
  logic        upd_q, upd_d, err_q, err_d;

  // Divider.
  logic [31:0] cmp_q, cmp_d, div_q, div_d, rem_q, rem_d;
  logic [39:0] num_q, num_d;
  logic [7:0]  low_q, low_d, quo_q, quo_d;
  logic [2:0]  step_q, step_d;

  logic [31:0] old_word, lane_mask, lane, merged, tick_inc;
  logic [4:0]  shamt;
  logic        valid_idx, is_ccer_wr, sel1, sel2;
  logic [32:0] trial;
  logic        trial_ge;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= command_i;
      idx_q  <= reg_index_i;
      off_q  <= byte_offset_i;
      size_q <= access_size_i;
      wd_q   <= write_data_i;
    end
    rd_q   <= rd_d;
    upd_q  <= upd_d;
    err_q  <= err_d;
    cmp_q  <= cmp_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    low_q  <= low_d;
    quo_q  <= quo_d;
    step_q <= step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr1_q   <= '0;
      dier_q  <= '0;
      sr_q    <= '0;
      ccmr1_q <= '0;
      ccmr2_q <= '0;
      ccer_q  <= '0;
      psc_q   <= '0;
      arr_q   <= '0;
      ccr1_q  <= '0;
      ccr2_q  <= '0;
      tick_q  <= '0;
      irq_q   <= 1'b0;
      en_q    <= 1'b0;
      ratio_q <= '0;
    end else begin
      cr1_q   <= cr1_d;
      dier_q  <= dier_d;
      sr_q    <= sr_d;
      ccmr1_q <= ccmr1_d;
      ccmr2_q <= ccmr2_d;
      ccer_q  <= ccer_d;
      psc_q   <= psc_d;
      arr_q   <= arr_d;
      ccr1_q  <= ccr1_d;
      ccr2_q  <= ccr2_d;
      tick_q  <= tick_d;
      irq_q   <= irq_d;
      en_q    <= en_d;
      ratio_q <= ratio_d;
    end
  end

  // Word read at the request index; unimplemented words read as zero.
  always_comb begin
    case (idx_q)
      btpwm_pkg::IdxCr1:   old_word = cr1_q;
      btpwm_pkg::IdxDier:  old_word = dier_q;
      btpwm_pkg::IdxSr:    old_word = sr_q;
      btpwm_pkg::IdxCcmr1: old_word = ccmr1_q;
      btpwm_pkg::IdxCcmr2: old_word = ccmr2_q;
      btpwm_pkg::IdxCcer:  old_word = ccer_q;
      btpwm_pkg::IdxPsc:   old_word = psc_q;
      btpwm_pkg::IdxArr:   old_word = arr_q;
      btpwm_pkg::IdxCcr1:  old_word = ccr1_q;
      btpwm_pkg::IdxCcr2:  old_word = ccr2_q;
      default:             old_word = '0;
    endcase
  end

  always_comb begin
    case (size_q)
      btpwm_pkg::Size1: lane_mask = 32'h0000_00ff;
      btpwm_pkg::Size2: lane_mask = 32'h0000_ffff;
      default:          lane_mask = 32'hffff_ffff;
    endcase
    shamt     = {off_q, 3'b000};
    lane      = lane_mask << shamt;
    // A full word write ignores the offset.
    merged    = (lane_mask == 32'hffff_ffff) ? wd_q
                : ((old_word & ~lane) | ((wd_q & lane_mask) << shamt));
    valid_idx = (32'(idx_q) < btpwm_pkg::NumRegs);
    is_ccer_wr = (cmd_q == btpwm_pkg::CmdWrite) && valid_idx
                 && (idx_q == btpwm_pkg::IdxCcer);
    sel1 = ((merged & btpwm_pkg::Cc1EnMask) != '0)
           && ((ccmr1_q & btpwm_pkg::Oc1ModeMask) == btpwm_pkg::Oc1ModeMask)
           && ((ccmr1_q & btpwm_pkg::Cc1SelMask) == '0);
    sel2 = ((merged & btpwm_pkg::Cc2EnMask) != '0)
           && ((ccmr1_q & btpwm_pkg::Oc2ModeMask) == btpwm_pkg::Oc2ModeMask)
           && ((ccmr1_q & btpwm_pkg::Cc2SelMask) == '0);
    tick_inc = tick_q + 32'd1;
    trial    = {rem_q, low_q[7]};
    trial_ge = (trial >= {1'b0, div_q});
  end

  always_comb begin
    status_o.need_div = is_ccer_wr && (sel1 || sel2) && (arr_q != '0);
    status_o.sat      = (num_q >= {div_q, 8'h00});
    status_o.div_last = (step_q == 3'd7);
  end

  always_comb begin
    cr1_d = cr1_q; dier_d = dier_q; sr_d = sr_q; ccmr1_d = ccmr1_q;
    ccmr2_d = ccmr2_q; ccer_d = ccer_q; psc_d = psc_q; arr_d = arr_q;
    ccr1_d = ccr1_q; ccr2_d = ccr2_q; tick_d = tick_q;
    irq_d = irq_q; en_d = en_q; ratio_d = ratio_q;
    rd_d = rd_q; upd_d = upd_q; err_d = err_q;
    cmp_d = cmp_q; div_d = div_q; rem_d = rem_q; num_d = num_q;
    low_d = low_q; quo_d = quo_q; step_d = step_q;

    if (cmd_i.exec) begin
      rd_d  = '0;
      upd_d = 1'b0;
      err_d = 1'b0;
      if ((cmd_q == btpwm_pkg::CmdRead) || (cmd_q == btpwm_pkg::CmdWrite)) begin
        if (!valid_idx) begin
          err_d = 1'b1;
        end else if (cmd_q == btpwm_pkg::CmdRead) begin
          rd_d = (old_word >> shamt) & lane_mask;
        end else begin
          case (idx_q)
            btpwm_pkg::IdxCr1: begin
              if (!cr1_q[0] && merged[0]) begin
                tick_d = '0;
                en_d   = 1'b1;
              end else if (cr1_q[0] && !merged[0]) begin
                en_d = 1'b0;
              end
              cr1_d = merged;
            end
            btpwm_pkg::IdxSr: begin
              if (sr_q[0] && !merged[0]) irq_d = 1'b0;
              sr_d = sr_q & merged;
            end
            btpwm_pkg::IdxCcer: begin
              ccer_d = merged;
              upd_d  = 1'b1;
              cmp_d  = sel1 ? ccr1_q : ccr2_q;
              div_d  = arr_q;
              if (!(sel1 || sel2)) begin
                ratio_d = '0;
              end else if (arr_q == '0) begin
                ratio_d = btpwm_pkg::RatioMax;
              end
            end
            btpwm_pkg::IdxDier:  dier_d  = merged;
            btpwm_pkg::IdxCcmr1: ccmr1_d = merged;
            btpwm_pkg::IdxCcmr2: ccmr2_d = merged;
            btpwm_pkg::IdxPsc:   psc_d   = merged;
            btpwm_pkg::IdxArr:   arr_d   = merged;
            btpwm_pkg::IdxCcr1:  ccr1_d  = merged;
            btpwm_pkg::IdxCcr2:  ccr2_d  = merged;
            default: ;
          endcase
        end
      end else if (cmd_q == btpwm_pkg::CmdTick) begin
        // Counting runs only while enabled in up-count mode.
        if (cr1_q[0] && ((cr1_q & btpwm_pkg::CntModeMask) == '0)) begin
          if (tick_inc >= arr_q) begin
            tick_d = '0;
            sr_d   = sr_q | 32'd1;
            irq_d  = 1'b1;
          end else begin
            tick_d = tick_inc;
          end
        end
      end
    end

    // compare * 255 as (compare << 8) - compare.
    if (cmd_i.prep) begin
      num_d = {cmp_q, 8'h00} - {8'h00, cmp_q};
    end

    // Below the saturation bound the high part is already smaller than ARR,
    // so eight restoring steps give the quotient.
    if (cmd_i.cmp) begin
      if (status_o.sat) begin
        ratio_d = btpwm_pkg::RatioMax;
      end else begin
        rem_d  = num_q[39:8];
        low_d  = num_q[7:0];
        quo_d  = '0;
        step_d = '0;
      end
    end

    if (cmd_i.div) begin
      rem_d  = trial_ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
      low_d  = {low_q[6:0], 1'b0};
      quo_d  = {quo_q[6:0], trial_ge};
      step_d = step_q + 3'd1;
      if (status_o.div_last) ratio_d = {quo_q[6:0], trial_ge};
    end
  end

  always_comb begin
    result_o.read_data = rd_q;
    result_o.irq       = irq_q;
    result_o.pwm_en    = en_q;
    result_o.ratio     = ratio_q;
    result_o.upd       = upd_q;
    result_o.err       = err_q;
  end

endmodule

FILE: rtl/basic_timer_with_pwm_ratio_unit.sv
// Top level of the timer with PWM ratio unit: controller, datapath, result register.
// The input channel carries one request at a time: a register read, a register
// write or one timer tick. A request is taken when in_valid_i is high and
// in_stall_o is low; in_stall_o stays high while a request is being worked on.
// Each request gives exactly one result on the output channel, held in a
// result register while out_stall_i is high; the unit then waits in its last
// step until that register is free.
// Reads, ticks and most writes pass from acceptance through an execute state
// and a finish state, where the result register is loaded; a new request can
// be taken in the cycle after that load. A CCER write that needs the duty
// ratio adds a product step, a saturation compare and, unless it saturates,
// eight steps of the restoring divider, one quotient bit per cycle.
// The interrupt, enable and ratio levels are those after the request.
// Reset clears all timer registers, the tick count and the interrupt, enable
// and ratio levels; the unit is ready for a request as soon as reset is released.
module basic_timer_with_pwm_ratio_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [4:0]  reg_index_i,
  input  logic [1:0]  byte_offset_i,
  input  logic [1:0]  access_size_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        irq_level_o,
  output logic        pwm_enable_level_o,
  output logic [7:0]  pwm_ratio_o,
  output logic        ratio_updated_o,
  output logic        access_error_o
);

  btpwm_pkg::dp_cmd_t    dp_cmd;
  btpwm_pkg::dp_status_t dp_status;
  btpwm_pkg::result_t    result, res_q;
  logic                  load, out_free;
  logic                  out_valid_q, out_valid_d;

  assign out_free = !out_valid_q || !out_stall_i;

  btpwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (dp_status),
    .in_stall_o (in_stall_o),
    .load_o     (load),
    .cmd_o      (dp_cmd)
  );

  btpwm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .command_i     (command_i),
    .reg_index_i   (reg_index_i),
    .byte_offset_i (byte_offset_i),
    .access_size_i (access_size_i),
    .write_data_i  (write_data_i),
    .status_o      (dp_status),
    .result_o      (result)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= result;
  end

  assign out_valid_o        = out_valid_q;
  assign read_data_o        = res_q.read_data;
  assign irq_level_o        = res_q.irq;
  assign pwm_enable_level_o = res_q.pwm_en;
  assign pwm_ratio_o        = res_q.ratio;
  assign ratio_updated_o    = res_q.upd;
  assign access_error_o     = res_q.err;

endmodule

FILE: tb/btpwm_result_checker.sv
// Checker for the timer with PWM ratio unit: predicts each result and compares it.
module btpwm_result_checker
  import btpwm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [4:0]  reg_index_i,
  input  logic [1:0]  byte_offset_i,
  input  logic [1:0]  access_size_i,
  input  logic [31:0] write_data_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [31:0] read_data_o,
  input  logic        irq_level_o,
  input  logic        pwm_enable_level_o,
  input  logic [7:0]  pwm_ratio_o,
  input  logic        ratio_updated_o,
  input  logic        access_error_o,
  output int          mismatch_count,
  output int          pending_count,
  output int          results_checked,
  output int          ratio_updates
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReports = 10;

  // Timer state as the unit should hold it.
  logic [31:0] timer_words [32];
  logic [31:0] tick_count;
  logic        irq_line;
  logic        enable_line;
  logic [7:0]  duty_ratio;

  result_t expected_results [$];
  result_t want;
  result_t got;

  function automatic logic [31:0] lane_mask_for(logic [1:0] size);
    case (size)
      Size1:   return 32'h0000_00ff;
      Size2:   return 32'h0000_ffff;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [7:0] duty_for(logic [31:0] cmp, logic [31:0] arr);
    logic [63:0] quotient;
    if (arr == 32'd0) return RatioMax;
    quotient = ({32'd0, cmp} * 64'd255) / {32'd0, arr};
    return (quotient > 64'd255) ? RatioMax : quotient[7:0];
  endfunction

  task automatic clear_timer_model();
    for (int i = 0; i < 32; i++) timer_words[i] = 32'd0;
    tick_count  = 32'd0;
    irq_line    = 1'b0;
    enable_line = 1'b0;
    duty_ratio  = 8'd0;
  endtask

  task automatic predict_timer_request(input logic [1:0] cmd, input logic [4:0] idx,
                                       input logic [1:0] off, input logic [1:0] size,
                                       input logic [31:0] wd);
    logic [31:0] mask;
    logic [31:0] old_word;
    logic [31:0] merged;
    logic [31:0] ccmr;
    logic [63:0] lane;
    logic [63:0] lane_data;
    result_t     res;
    res  = '0;
    mask = lane_mask_for(size);
    if (cmd == CmdRead || cmd == CmdWrite) begin
      if (idx >= NumRegs) begin
        res.err = 1'b1;
      end else if (cmd == CmdRead) begin
        res.read_data = (timer_words[idx] >> {off, 3'b000}) & mask;
      end else begin
        old_word = timer_words[idx];
        if (mask == 32'hffff_ffff) begin
          merged = wd;
        end else begin
          // Lanes shifted past byte 3 fall off the word.
          lane      = {32'd0, mask} << {off, 3'b000};
          lane_data = {32'd0, wd & mask} << {off, 3'b000};
          merged    = (old_word & ~lane[31:0]) | lane_data[31:0];
        end
        case (idx)
          IdxCr1: begin
            if (!old_word[0] && merged[0]) begin
              tick_count  = 32'd0;
              enable_line = 1'b1;
            end else if (old_word[0] && !merged[0]) begin
              enable_line = 1'b0;
            end
            timer_words[idx] = merged;
          end
          IdxSr: begin
            if (old_word[0] && !merged[0]) irq_line = 1'b0;
            timer_words[idx] = old_word & merged;
          end
          IdxCcer: begin
            timer_words[idx] = merged;
            ccmr = timer_words[IdxCcmr1];
            if ((merged & Cc1EnMask) != 0 && (ccmr & Oc1ModeMask) == Oc1ModeMask &&
                (ccmr & Cc1SelMask) == 0) begin
              duty_ratio = duty_for(timer_words[IdxCcr1], timer_words[IdxArr]);
            end else if ((merged & Cc2EnMask) != 0 && (ccmr & Oc2ModeMask) == Oc2ModeMask &&
                         (ccmr & Cc2SelMask) == 0) begin
              duty_ratio = duty_for(timer_words[IdxCcr2], timer_words[IdxArr]);
            end else begin
              duty_ratio = 8'd0;
            end
            res.upd = 1'b1;
          end
          IdxDier, IdxCcmr1, IdxCcmr2, IdxPsc, IdxArr, IdxCcr1, IdxCcr2: begin
            timer_words[idx] = merged;
          end
          default: ;
        endcase
      end
    end else if (cmd == CmdTick) begin
      if (timer_words[IdxCr1][0] && (timer_words[IdxCr1] & CntModeMask) == 0) begin
        tick_count = tick_count + 32'd1;
        if (tick_count >= timer_words[IdxArr]) begin
          tick_count          = 32'd0;
          timer_words[IdxSr][0] = 1'b1;
          irq_line            = 1'b1;
        end
      end
    end
    res.irq    = irq_line;
    res.pwm_en = enable_line;
    res.ratio  = duty_ratio;
    expected_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_timer_model();
      expected_results.delete();
      mismatch_count  = 0;
      results_checked = 0;
      ratio_updates   = 0;
      pending_count  <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_timer_request(command_i, reg_index_i, byte_offset_i, access_size_i,
                              write_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{read_data: read_data_o, irq: irq_level_o, pwm_en: pwm_enable_level_o,
                ratio: pwm_ratio_o, upd: ratio_updated_o, err: access_error_o};
        if (expected_results.size() == 0) begin
          if (mismatch_count < MaxReports) begin
            $display("%0t: result with no request waiting: rd=%h irq=%b en=%b ratio=%0d",
                     $realtime, got.read_data, got.irq, got.pwm_en, got.ratio);
          end
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.upd) ratio_updates++;
          if (got.read_data !== want.read_data || got.irq !== want.irq ||
              got.pwm_en !== want.pwm_en || got.ratio !== want.ratio ||
              got.upd !== want.upd || got.err !== want.err) begin
            if (mismatch_count < MaxReports) begin
              $display("%0t: mismatch exp rd=%h irq=%b en=%b ratio=%0d upd=%b err=%b",
                       $realtime, want.read_data, want.irq, want.pwm_en, want.ratio,
                       want.upd, want.err);
              $display("%0t:          got rd=%h irq=%b en=%b ratio=%0d upd=%b err=%b",
                       $realtime, got.read_data, got.irq, got.pwm_en, got.ratio,
                       got.upd, got.err);
            end
            mismatch_count++;
          end
        end
      end
      pending_count <= expected_results.size();
    end
  end

endmodule

FILE: tb/tb.sv
// Testbench top of the timer with PWM ratio unit: stimulus, output stalls and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btpwm_pkg::*;

  localparam logic [1:0] Size4        = 2'd2;
  localparam logic [1:0] SizeOdd      = 2'd3;
  localparam logic [1:0] CmdNone      = 2'd3;
  localparam logic [4:0] IdxUnmapped  = 5'd1;
  localparam logic [4:0] IdxBadFirst  = 5'(NumRegs);
  localparam logic [4:0] IdxBadLast   = 5'd31;
  localparam int         RandomPerPhase = 460;
  localparam int         LongHoldCycles = 300;
  localparam int         MaxGap         = 20;
  localparam int         DrainCycles    = 30;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CmdRead;
  logic [4:0]  reg_index_i = IdxCr1;
  logic [1:0]  byte_offset_i = 2'd0;
  logic [1:0]  access_size_i = Size4;
  logic [31:0] write_data_i = 32'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] read_data_o;
  logic        irq_level_o;
  logic        pwm_enable_level_o;
  logic [7:0]  pwm_ratio_o;
  logic        ratio_updated_o;
  logic        access_error_o;

  int mismatch_count;
  int pending_count;
  int results_checked;
  int ratio_updates;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_requests = 0;
  int          holds_done = 0;
  int          directed_sent = 0;
  int          random_sent = 0;

  basic_timer_with_pwm_ratio_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .reg_index_i,
    .byte_offset_i, .access_size_i, .write_data_i, .out_valid_o, .out_stall_i,
    .read_data_o, .irq_level_o, .pwm_enable_level_o, .pwm_ratio_o,
    .ratio_updated_o, .access_error_o
  );

  btpwm_result_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .reg_index_i,
    .byte_offset_i, .access_size_i, .write_data_i, .out_valid_o, .out_stall_i,
    .read_data_o, .irq_level_o, .pwm_enable_level_o, .pwm_ratio_o,
    .ratio_updated_o, .access_error_o, .mismatch_count, .pending_count,
    .results_checked, .ratio_updates
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("tb failed");
    $finish;
  end

  // Output side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_done < hold_requests) begin
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
        holds_done++;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offers one request and returns at the edge where it was taken. Valid stays
  // high when the next request follows without a gap.
  task automatic issue_request(input logic [1:0] cmd, input logic [4:0] idx,
                               input logic [1:0] off, input logic [1:0] size,
                               input logic [31:0] wd);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    reg_index_i   <= idx;
    byte_offset_i <= off;
    access_size_i <= size;
    write_data_i  <= wd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [4:0] stored_index(int unsigned k);
    case (k)
      0:       return IdxCr1;
      1:       return IdxDier;
      2:       return IdxSr;
      3:       return IdxCcmr1;
      4:       return IdxCcmr2;
      5:       return IdxCcer;
      6:       return IdxPsc;
      7:       return IdxArr;
      8:       return IdxCcr1;
      default: return IdxCcr2;
    endcase
  endfunction

  // Write data shaped so the counter runs, fires and the ratio paths get used.
  function automatic logic [31:0] shaped_data(logic [4:0] idx);
    logic [31:0] value;
    value = $urandom;
    if ($urandom_range(9) == 0) return value;
    case (idx)
      IdxCr1:   value = {31'd0, 1'($urandom_range(1))};
      IdxArr:   value = $urandom_range(12);
      IdxSr:    value = ($urandom_range(1) != 0) ? 32'd0 : value;
      IdxCcmr1: begin
        value = value & ~(Cc1SelMask | Cc2SelMask);
        if ($urandom_range(1) != 0) value = value | Oc1ModeMask;
        if ($urandom_range(1) != 0) value = value | Oc2ModeMask;
      end
      IdxCcr1, IdxCcr2: begin
        if ($urandom_range(9) < 6) value = $urandom_range(20);
      end
      default: ;
    endcase
    return value;
  endfunction

  task automatic random_request();
    int unsigned pick;
    logic [1:0]  cmd;
    logic [4:0]  idx;
    logic [1:0]  off;
    logic [1:0]  size;
    pick = $urandom_range(99);
    if (pick < 36)      cmd = CmdTick;
    else if (pick < 70) cmd = CmdWrite;
    else if (pick < 96) cmd = CmdRead;
    else                cmd = CmdNone;
    pick = $urandom_range(99);
    if (pick < 80)      idx = stored_index($urandom_range(9));
    else if (pick < 92) idx = 5'($urandom_range(NumRegs - 1));
    else                idx = 5'($urandom_range(31, NumRegs));
    if ($urandom_range(9) < 6) begin
      size = Size4;
      off  = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd0;
    end else begin
      size = 2'($urandom_range(3));
      off  = 2'($urandom_range(3));
    end
    issue_request(cmd, idx, off, size, shaped_data(idx));
    random_sent++;
  endtask

  task automatic directed_request(input logic [1:0] cmd, input logic [4:0] idx,
                                  input logic [1:0] off, input logic [1:0] size,
                                  input logic [31:0] wd);
    issue_request(cmd, idx, off, size, wd);
    directed_sent++;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Invalid indexes, then a counter run that fires on the fourth tick.
    directed_request(CmdRead, IdxBadLast, 2'd0, Size4, 32'd0);
    directed_request(CmdWrite, IdxBadFirst, 2'd0, Size4, 32'hffff_ffff);
    directed_request(CmdWrite, IdxArr, 2'd0, Size2, 32'hffff_0004);
    directed_request(CmdWrite, IdxCr1, 2'd0, Size1, 32'h0000_0001);
    repeat (4) directed_request(CmdTick, IdxCr1, 2'd0, Size4, 32'd0);
    directed_request(CmdRead, IdxSr, 2'd0, Size1, 32'd0);
    directed_request(CmdWrite, IdxSr, 2'd0, Size4, 32'd0);
    // Ratio: plain, saturated, zero ARR through the second channel, and none.
    directed_request(CmdWrite, IdxCcmr1, 2'd0, SizeOdd, 32'h0000_6060);
    directed_request(CmdWrite, IdxCcr1, 2'd0, Size4, 32'd2);
    directed_request(CmdWrite, IdxCcer, 2'd0, Size4, 32'd1);
    directed_request(CmdWrite, IdxCcr1, 2'd0, Size4, 32'hffff_ffff);
    directed_request(CmdWrite, IdxCcer, 2'd0, Size4, 32'd1);
    directed_request(CmdWrite, IdxArr, 2'd0, Size4, 32'd0);
    directed_request(CmdWrite, IdxCcer, 2'd0, Size4, 32'h0000_0010);
    directed_request(CmdWrite, IdxCcer, 2'd0, Size4, 32'd0);
    directed_request(CmdNone, IdxCr1, 2'd0, Size4, 32'hffff_ffff);
    // A word read with an offset, and a narrow write that runs past byte 3.
    directed_request(CmdRead, IdxCcr1, 2'd3, Size4, 32'd0);
    directed_request(CmdWrite, IdxDier, 2'd3, Size2, 32'hffff_abcd);
    directed_request(CmdRead, IdxDier, 2'd2, Size2, 32'd0);
    // Down-count mode ignores ticks even with ARR at zero.
    directed_request(CmdWrite, IdxCr1, 2'd0, Size2, 32'h0000_0011);
    directed_request(CmdTick, IdxCr1, 2'd0, Size4, 32'd0);
    directed_request(CmdWrite, IdxCr1, 2'd0, Size4, 32'd0);
    directed_request(CmdWrite, IdxUnmapped, 2'd0, Size4, 32'hffff_ffff);
    directed_request(CmdRead, IdxUnmapped, 2'd0, Size4, 32'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      // The output holds off while requests keep coming, so the input stalls.
      if (phase == 0) hold_requests++;
      repeat (RandomPerPhase) random_request();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d directed and %0d random requests over four idle phases.",
             directed_sent, random_sent);
    $display("Checked %0d results, %0d of them ratio updates, with %0d long output hold-off.",
             results_checked, ratio_updates, holds_done);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
